// ===== rtl/tlfr_pkg.sv =====
`timescale 1ns / 1ps

package tlfr_pkg;

	// Header layout: one type byte, then four length bytes, little-endian
	localparam int unsigned HdrBytes = 5;
	localparam logic [2:0] HDR_TYPE_IDX = 3'd0;
	localparam logic [2:0] HDR_LAST_IDX = 3'(HdrBytes - 1);

	typedef logic [2:0]  hdr_idx_t;
	typedef logic [7:0]  byte_t;
	typedef logic [31:0] len_t;

	// One result item as it leaves the deframer
	typedef struct packed {
		byte_t payload_byte;
		byte_t packet_type;
		len_t  packet_length;
		logic  is_last;
		logic  empty_packet;
	} res_t;

	// Result handed from the parser to the output buffer
	typedef struct packed {
		logic valid;
		res_t res;
	} res_push_t;

endpackage

// ===== rtl/tlfr_in_if.sv =====
`timescale 1ns / 1ps

interface tlfr_in_if;
	logic             valid;
	logic             ready;
	tlfr_pkg::byte_t  data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/tlfr_out_if.sv =====
`timescale 1ns / 1ps

interface tlfr_out_if;
	logic             valid;
	logic             ready;
	tlfr_pkg::byte_t  payload_byte;
	tlfr_pkg::byte_t  packet_type;
	tlfr_pkg::len_t   packet_length;
	logic             is_last;
	logic             empty_packet;

	modport source (output valid, output payload_byte, output packet_type,
		output packet_length, output is_last, output empty_packet, input ready);
	modport sink (input valid, input payload_byte, input packet_type,
		input packet_length, input is_last, input empty_packet, output ready);
endinterface

// ===== rtl/type_length_frame_receiver.sv =====
`timescale 1ns / 1ps

// Type-length frame receiver.
// The stream channel carries one raw byte per item. Each packet is a type
// byte, a 32-bit little-endian payload length, then that many payload bytes.
// The packet channel gives one item per payload byte, carrying the byte, the
// packet's type and length; is_last marks the final byte of a packet. A
// packet of zero length gives a single item with empty_packet and is_last
// set and payload_byte zero, caused by its last header byte.
// Other header bytes give no item.
// A result is registered in the output register, or in the skid stage while
// the receiver stalls. Throughput: one byte per clock while the skid stage
// is empty, limited by the single framing state update per accepted byte.
// An output register plus a one-entry skid stage sit on the packet side:
// while the receiver stalls, stream.ready stays high until the skid stage
// fills, then drops until an item is taken.
// Reset (arst_n low) clears the framing state and empties the output
// register and the skid stage; the first byte after reset is read as a
// type byte.

module type_length_frame_receiver (
	input logic     clk,
	input logic     arst_n,
	tlfr_in_if.sink   stream,
	tlfr_out_if.source packet
);
	import tlfr_pkg::*;

	logic      take;
	logic      can_take;
	res_push_t push;
	res_t      out_res;

	assign stream.ready = can_take;
	assign take = stream.valid && can_take;

	tlfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (stream.data_byte),
		.push      (push)
	);

	tlfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.can_take  (can_take),
		.out_valid (packet.valid),
		.out_res   (out_res),
		.out_ready (packet.ready)
	);

	assign packet.payload_byte = out_res.payload_byte;
	assign packet.packet_type = out_res.packet_type;
	assign packet.packet_length = out_res.packet_length;
	assign packet.is_last = out_res.is_last;
	assign packet.empty_packet = out_res.empty_packet;

endmodule

// ===== rtl/tlfr_parse.sv =====
`timescale 1ns / 1ps

module tlfr_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  tlfr_pkg::byte_t     data_byte,
	output tlfr_pkg::res_push_t push
);
	import tlfr_pkg::*;

	hdr_idx_t header_count_q;
	logic     in_payload_q;
	byte_t    held_type_q;
	len_t     held_length_q;
	len_t     payload_count_q;

	hdr_idx_t idx;
	len_t     count_inc;
	len_t     length_next;
	logic     pay_last;
	logic     hdr_done;

	// Clamp the header position and merge the incoming length byte
	always_comb begin
		idx = (header_count_q > HDR_LAST_IDX) ? HDR_LAST_IDX : header_count_q;
		length_next = held_length_q;
		case (idx)
			3'd0: length_next = '0;
			3'd1: length_next[7:0] = data_byte;
			3'd2: length_next[15:8] = data_byte;
			3'd3: length_next[23:16] = data_byte;
			3'd4: length_next[31:24] = data_byte;
			default: length_next = held_length_q;
		endcase
		hdr_done = (idx == HDR_LAST_IDX);
		count_inc = payload_count_q + 32'd1;
		pay_last = (count_inc == held_length_q);
	end

	// Form the result for this item
	always_comb begin
		push.valid = 1'b0;
		push.res.payload_byte = data_byte;
		push.res.packet_type = held_type_q;
		push.res.packet_length = held_length_q;
		push.res.is_last = pay_last;
		push.res.empty_packet = 1'b0;
		if (in_payload_q) begin
			push.valid = take;
		end else begin
			push.res.payload_byte = '0;
			push.res.packet_length = '0;
			push.res.is_last = 1'b1;
			push.res.empty_packet = 1'b1;
			push.valid = take && hdr_done && (length_next == '0);
		end
	end

	// Advance the framing state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			in_payload_q <= 1'b0;
			held_type_q <= '0;
			held_length_q <= '0;
			payload_count_q <= '0;
		end else if (take) begin
			if (in_payload_q) begin
				if (pay_last) begin
					in_payload_q <= 1'b0;
					payload_count_q <= '0;
				end else begin
					payload_count_q <= count_inc;
				end
			end else begin
				if (idx == HDR_TYPE_IDX) begin
					held_type_q <= data_byte;
				end
				held_length_q <= length_next;
				if (hdr_done) begin
					header_count_q <= '0;
					payload_count_q <= '0;
					in_payload_q <= (length_next != '0);
				end else begin
					header_count_q <= idx + 3'd1;
				end
			end
		end
	end

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		header_count_q <= HDR_LAST_IDX)
		else $error("header position out of range");

	a_payload_no_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> header_count_q == '0)
		else $error("header position moved during payload");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> payload_count_q < held_length_q)
		else $error("payload count reached length while in payload");

endmodule

// ===== rtl/tlfr_out_buf.sv =====
`timescale 1ns / 1ps

module tlfr_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  tlfr_pkg::res_push_t push,
	output logic                can_take,
	output logic                out_valid,
	output tlfr_pkg::res_t      out_res,
	input  logic                out_ready
);
	import tlfr_pkg::*;

	logic main_valid_q;
	res_t main_q;
	logic skid_valid_q;
	res_t skid_q;
	logic pop;

	assign pop = main_valid_q && out_ready;
	assign can_take = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res = main_q;

	// Control: refill the output register from the skid stage first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			main_valid_q <= skid_valid_q || push.valid;
			skid_valid_q <= 1'b0;
		end else if (push.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push.res;
		end else if (push.valid) begin
			skid_q <= push.res;
		end
	end

	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid stage full while output register empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push.valid)
		else $error("item pushed while skid stage full");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> main_valid_q && !skid_valid_q)
		else $error("skid stage not moved to output register");

endmodule
